### sv/tswdt_pkg.sv
// ----------------------------------------------------------------------------
// Two-stage watchdog register block: shared definitions
// Item and result words, operation codes, register offsets, keys and the
// one-hot stage encoding.
// ----------------------------------------------------------------------------
package tswdt_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned AddrW   = 8;
  localparam int unsigned BaseW   = 16;
  localparam int unsigned TicksW  = 31;

  localparam logic [BaseW-1:0] BaseReset = 16'd100;

  localparam logic [DataW-1:0] IdWord     = 32'h0300_2004;
  localparam logic [15:0]      RestartKey = 16'hCAFE;
  localparam logic [15:0]      UnlockKey  = 16'h5AA5;

  localparam logic [AddrW-1:0] OffId      = 8'h00;
  localparam logic [AddrW-1:0] OffCtrl    = 8'h10;
  localparam logic [AddrW-1:0] OffRestart = 8'h14;
  localparam logic [AddrW-1:0] OffWrEn    = 8'h18;
  localparam logic [AddrW-1:0] OffStatus  = 8'h1C;

  // Control word bit positions.
  localparam int unsigned CtrlEn    = 0;
  localparam int unsigned CtrlIntEn = 2;
  localparam int unsigned CtrlRstEn = 3;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_INT  = 4'b0010,
    ST_RST  = 4'b0100,
    ST_DONE = 4'b1000
  } stage_e;

  typedef struct packed {
    logic [1:0]       operation;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             irq;
    logic             reset_request;
  } result_t;

endpackage

### sv/tswdt_core.sv
// ----------------------------------------------------------------------------
// Two-stage watchdog core
// Holds the register state and the countdown, and works out the result of
// one item in a single pass whenever step_i is high.
// ----------------------------------------------------------------------------
module tswdt_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tswdt_pkg::BaseW-1:0]    cfg_wdata_i,
  input  logic                           step_i,
  input  tswdt_pkg::item_t               item_i,
  output tswdt_pkg::result_t             result_o
);

  typedef struct packed {
    tswdt_pkg::stage_e                stage;
    logic [tswdt_pkg::TicksW-1:0]     ticks;
  } reload_t;

  logic [tswdt_pkg::BaseW-1:0]  base_q;
  logic [tswdt_pkg::DataW-1:0]  ctrl_q, ctrl_d;
  logic                         expired_q, expired_d;
  logic                         unlocked_q, unlocked_d;
  tswdt_pkg::stage_e            stage_q, stage_d;
  logic [tswdt_pkg::TicksW-1:0] ticks_q, ticks_d;
  logic                         irq_q, irq_d;

  function automatic logic [tswdt_pkg::TicksW-1:0] period(
    input logic [tswdt_pkg::BaseW-1:0] base,
    input logic [3:0]                  exp
  );
    logic [tswdt_pkg::TicksW-1:0] wide;
    wide = {{(tswdt_pkg::TicksW-tswdt_pkg::BaseW){1'b0}}, base};
    return wide << exp;
  endfunction

  function automatic reload_t reload(
    input logic [tswdt_pkg::DataW-1:0] ctrl,
    input logic [tswdt_pkg::BaseW-1:0] base
  );
    reload_t r;
    if (!ctrl[tswdt_pkg::CtrlEn]) begin
      r.stage = tswdt_pkg::ST_IDLE;
      r.ticks = '0;
    end else if (ctrl[tswdt_pkg::CtrlIntEn]) begin
      r.stage = tswdt_pkg::ST_INT;
      r.ticks = period(base, ctrl[7:4]);
    end else begin
      r.stage = tswdt_pkg::ST_RST;
      r.ticks = period(base, {1'b0, ctrl[10:8]});
    end
    return r;
  endfunction

  reload_t rl;

  always_comb begin
    ctrl_d     = ctrl_q;
    expired_d  = expired_q;
    unlocked_d = unlocked_q;
    stage_d    = stage_q;
    ticks_d    = ticks_q;
    irq_d      = irq_q;
    rl         = '0;
    result_o   = '0;

    unique case (item_i.operation)
      tswdt_pkg::OP_READ: begin
        unique case (item_i.address)
          tswdt_pkg::OffId:     result_o.read_data = tswdt_pkg::IdWord;
          tswdt_pkg::OffCtrl:   result_o.read_data = ctrl_q;
          tswdt_pkg::OffStatus: result_o.read_data = {31'b0, expired_q};
          default:              result_o.read_data = '0;
        endcase
      end
      tswdt_pkg::OP_WRITE: begin
        unique case (item_i.address)
          tswdt_pkg::OffCtrl: begin
            if (unlocked_q) begin
              unlocked_d = 1'b0;
              ctrl_d     = item_i.write_data;
              rl         = reload(item_i.write_data, base_q);
              stage_d    = rl.stage;
              ticks_d    = rl.ticks;
            end
          end
          tswdt_pkg::OffRestart: begin
            if (item_i.write_data[15:0] == tswdt_pkg::RestartKey) begin
              rl      = reload(ctrl_q, base_q);
              stage_d = rl.stage;
              ticks_d = rl.ticks;
              irq_d   = 1'b0;
            end
          end
          tswdt_pkg::OffWrEn: begin
            unlocked_d = (item_i.write_data[15:0] == tswdt_pkg::UnlockKey);
          end
          tswdt_pkg::OffStatus: begin
            if (item_i.write_data[0]) begin
              expired_d = 1'b0;
              irq_d     = 1'b0;
            end
          end
          default: ;
        endcase
      end
      tswdt_pkg::OP_TICK: begin
        unique case (stage_q)
          tswdt_pkg::ST_INT, tswdt_pkg::ST_RST: begin
            if (ticks_q > 31'd1) begin
              ticks_d = ticks_q - 31'd1;
            end else if (stage_q == tswdt_pkg::ST_INT) begin
              // Interrupt stage ran out: flag it and go on to the reset stage.
              expired_d = 1'b1;
              irq_d     = 1'b1;
              stage_d   = tswdt_pkg::ST_RST;
              ticks_d   = period(base_q, {1'b0, ctrl_q[10:8]});
            end else begin
              stage_d                = tswdt_pkg::ST_DONE;
              ticks_d                = '0;
              result_o.reset_request = ctrl_q[tswdt_pkg::CtrlRstEn];
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    result_o.irq = irq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= tswdt_pkg::BaseReset;
      ctrl_q     <= '0;
      expired_q  <= 1'b0;
      unlocked_q <= 1'b0;
      stage_q    <= tswdt_pkg::ST_IDLE;
      ticks_q    <= '0;
      irq_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (step_i) begin
        ctrl_q     <= ctrl_d;
        expired_q  <= expired_d;
        unlocked_q <= unlocked_d;
        stage_q    <= stage_d;
        ticks_q    <= ticks_d;
        irq_q      <= irq_d;
      end
    end
  end

endmodule

### sv/two_stage_watchdog_registers_top.sv
// ----------------------------------------------------------------------------
// Two-stage watchdog register block, top level
// Bus reads, bus writes and timer ticks enter as words; each word gives one
// result word with read data, interrupt level and reset request.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i / in_stall_o   operation, address, write_data
//   out       output     out_valid_o / out_stall_i read_data, irq, reset_request
//   cfg       input      cfg_we_i                  cfg_wdata_i (base period ticks)
//
// One word is taken per cycle while in_stall_o is low; its result word is
// presented in the result register once the word leaves the input register.
// The core updates its state as a word moves from the input register into the
// result register, so consecutive words see each other's effects in order.
// A stall on the output holds the result register and then the input register;
// in_stall_o rises only while both are full and the output is stalled.
// Reset empties both registers, clears the control state and the countdown, and
// sets the base period to 100 ticks.
// ----------------------------------------------------------------------------
module two_stage_watchdog_registers_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tswdt_pkg::BaseW-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    operation_i,
  input  logic [tswdt_pkg::AddrW-1:0]   address_i,
  input  logic [tswdt_pkg::DataW-1:0]   write_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tswdt_pkg::DataW-1:0]   read_data_o,
  output logic                          irq_o,
  output logic                          reset_request_o
);

  logic                in_valid_q;
  tswdt_pkg::item_t    item_q;
  logic                out_valid_q;
  tswdt_pkg::result_t  res_q, res_d;
  logic                step;

  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;

  tswdt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (item_q),
    .result_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= '{operation: operation_i, address: address_i, write_data: write_data_i};
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = res_q.read_data;
  assign irq_o           = res_q.irq;
  assign reset_request_o = res_q.reset_request;

endmodule

### sv/tswdt_checker.sv
// ----------------------------------------------------------------------------
// Two-stage watchdog port checker
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module tswdt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [tswdt_pkg::BaseW-1:0]   cfg_wdata_i,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [1:0]                    operation_i,
  input logic [tswdt_pkg::AddrW-1:0]   address_i,
  input logic [tswdt_pkg::DataW-1:0]   write_data_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [tswdt_pkg::DataW-1:0]   read_data_o,
  input logic                          irq_o,
  input logic                          reset_request_o
);

  // A stalled result word must hold.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o)
      && $stable(irq_o) && $stable(reset_request_o))
    else $error("stalled result word changed");

  // The input only backs up when a result word is waiting behind a stall.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // A reset request comes from a tick, which never carries read data.
  a_rr_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reset_request_o |-> read_data_o == '0)
    else $error("reset request with read data");

  // A fresh word only enters when the input register can move on.
  a_stall_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty output");

endmodule

bind two_stage_watchdog_registers_top tswdt_checker u_tswdt_checker (.*);
